[rtl/key_press_duration_classifier_macros.svh]
// Assertion macros for the key press duration classifier checker.
// Each macro expands to one labeled concurrent assertion on a given clock.
`ifndef KEY_PRESS_DURATION_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_MACROS_SVH

// Assertion that is switched off while reset is high.
`define KPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds through reset.
`define KPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/kpd_pkg.sv]
// Shared types and constants of the key press duration classifier.
// No dependencies; used by every module of the block.
package kpd_pkg;

  localparam int LIMIT_W     = 16;
  localparam int CFG_INDEX_W = 4;

  // Request kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Key event codes: base of each key, then +1 middle, +2 long
  localparam logic [3:0] EVENT_NONE      = 4'd0;
  localparam logic [3:0] EVENT_UP_BASE   = 4'd1;
  localparam logic [3:0] EVENT_DOWN_BASE = 4'd4;
  localparam logic [3:0] EVENT_MODE_BASE = 4'd7;
  localparam logic [3:0] EVENT_LAST      = 4'd9;

  // LED color hints
  localparam logic [1:0] LED_NO_CHANGE = 2'd0;
  localparam logic [1:0] LED_BLACK     = 2'd1;
  localparam logic [1:0] LED_WHITE     = 2'd2;
  localparam logic [1:0] LED_RED       = 2'd3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BOUNCE_LIMIT     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIDDLE_LIMIT     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE_ACTIVE_HIGH = 4'd3;

  // Register reset values
  localparam logic [LIMIT_W-1:0] BOUNCE_LIMIT_RESET = 16'd50;
  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RESET  = 16'd1000;
  localparam logic [LIMIT_W-1:0] MIDDLE_LIMIT_RESET = 16'd3000;
  localparam logic               MODE_HIGH_RESET    = 1'b1;

  // Key positions in the level vector
  localparam int KEY_UP   = 0;
  localparam int KEY_DOWN = 1;
  localparam int KEY_MODE = 2;
  localparam int KEY_COUNT = 3;

  typedef struct packed {
    logic kind;
    logic up_level;
    logic down_level;
    logic mode_level;
    logic bt_working;
  } item_t;

  typedef struct packed {
    logic [3:0] key_event;
    logic [1:0] led_color;
    logic       mute_request;
    logic       restore_request;
  } result_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] bounce_limit;
    logic [LIMIT_W-1:0] short_limit;
    logic [LIMIT_W-1:0] middle_limit;
    logic               mode_active_high;
  } cfg_t;

  function automatic logic [3:0] key_base(input logic [1:0] key);
    logic [3:0] base;
    case (key)
      2'd0:    base = EVENT_UP_BASE;
      2'd1:    base = EVENT_DOWN_BASE;
      2'd2:    base = EVENT_MODE_BASE;
      default: base = EVENT_NONE;
    endcase
    return base;
  endfunction

endpackage

[rtl/kpd_cfg_regs.sv]
// Configuration register file: limits and mode key polarity.
// Depends on kpd_pkg.
module kpd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kpd_pkg::LIMIT_W-1:0]      cfg_data,
  output kpd_pkg::cfg_t                    cfg
);
  import kpd_pkg::*;

  cfg_t regs;

  assign cfg_ready = !rst;
  assign cfg      = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.bounce_limit     <= BOUNCE_LIMIT_RESET;
      regs.short_limit      <= SHORT_LIMIT_RESET;
      regs.middle_limit     <= MIDDLE_LIMIT_RESET;
      regs.mode_active_high <= MODE_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOUNCE_LIMIT:     regs.bounce_limit     <= cfg_data;
        REG_SHORT_LIMIT:      regs.short_limit      <= cfg_data;
        REG_MIDDLE_LIMIT:     regs.middle_limit     <= cfg_data;
        REG_MODE_ACTIVE_HIGH: regs.mode_active_high <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/kpd_core.sv]
// Update logic for one request: timer advance, key edges, classification.
// Depends on kpd_pkg.
module kpd_core #(
  parameter int TIMER_BITS = 16
) (
  input  kpd_pkg::item_t          item,
  input  kpd_pkg::cfg_t           cfg,
  input  logic [TIMER_BITS-1:0]   press_timer,
  input  logic                    timer_running,
  input  logic [2:0]              previous_levels,
  output logic [TIMER_BITS-1:0]   press_timer_next,
  output logic                    timer_running_next,
  output logic [2:0]              previous_levels_next,
  output kpd_pkg::result_t        result
);
  import kpd_pkg::*;

  localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [2:0] levels;
  logic [2:0] pressed;

  assign levels  = {item.mode_level, item.down_level, item.up_level};
  assign pressed = {item.mode_level == cfg.mode_active_high,
                    !item.down_level, !item.up_level};

  always_comb begin
    logic [TIMER_BITS-1:0] t;
    logic                  run;
    logic [CMP_W-1:0]      t_ext;
    logic [CMP_W-1:0]      b_ext;
    logic [CMP_W-1:0]      s_ext;
    logic [CMP_W-1:0]      m_ext;

    t      = press_timer;
    run    = timer_running;
    t_ext  = '0;
    b_ext  = CMP_W'(cfg.bounce_limit);
    s_ext  = CMP_W'(cfg.short_limit);
    m_ext  = CMP_W'(cfg.middle_limit);
    result = '0;

    if (item.kind == KIND_TICK) begin
      if (run) begin
        if (t != TIMER_MAX) begin
          t = t + 1'b1;
        end
        t_ext = CMP_W'(t);
        if (t_ext <= b_ext) begin
          result.led_color = LED_BLACK;
        end else if (t_ext < s_ext) begin
          result.led_color = LED_NO_CHANGE;
        end else if (t_ext < m_ext) begin
          result.led_color = LED_WHITE;
        end else begin
          result.led_color = LED_RED;
        end
      end
    end else begin
      // Walk keys in order up, down, mode; each sees the timer left by the last
      for (int k = 0; k < KEY_COUNT; k++) begin
        t_ext = CMP_W'(t);
        if (levels[k] != previous_levels[k]) begin
          if (pressed[k]) begin
            run = 1'b1;
            t   = '0;
            if (!item.bt_working) begin
              result.mute_request = 1'b1;
            end
          end else begin
            if (t_ext > b_ext) begin
              if (t_ext < s_ext) begin
                result.key_event = key_base(k[1:0]);
              end else if (t_ext < m_ext) begin
                result.key_event = key_base(k[1:0]) + 4'd1;
              end else begin
                result.key_event = key_base(k[1:0]) + 4'd2;
              end
            end
            run = 1'b0;
            if (!item.bt_working) begin
              result.restore_request = 1'b1;
            end
          end
        end
      end
    end

    press_timer_next   = t;
    timer_running_next = run;
  end

  assign previous_levels_next = (item.kind == KIND_SAMPLE) ? levels : previous_levels;

endmodule

[rtl/key_press_duration_classifier.sv]
// Top level of the key press duration classifier: input register, update
// logic, key state and result register. Depends on kpd_pkg, kpd_cfg_regs, kpd_core.
//
//   channel   signals                              direction
//   item      item_valid/item_ready/item_data      requests in (tick or pin sample)
//   result    result_valid/result_ready/result_data one result per request out
//   cfg       cfg_valid/cfg_ready/cfg_index/cfg_data register writes in
//
// One request per cycle sustained while results are taken; a request passes through
// the input register, then is updated into the result register.
// Key state updates as a request moves from the input register to the result register.
// A stalled result holds the result register; the input register still takes a
// request while empty, then holds until the result register frees.
// Synchronous reset clears the valid flags and key state and sets the configuration registers to their defaults.
module key_press_duration_classifier #(
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  kpd_pkg::item_t                  item_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output kpd_pkg::result_t                result_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kpd_pkg::LIMIT_W-1:0]     cfg_data
);
  import kpd_pkg::*;

  cfg_t                  cfg;
  logic                  stage_valid;
  item_t                 stage_item;
  logic                  advance;
  logic [TIMER_BITS-1:0] press_timer;
  logic [TIMER_BITS-1:0] press_timer_next;
  logic                  timer_running;
  logic                  timer_running_next;
  logic [2:0]            previous_levels;
  logic [2:0]            previous_levels_next;
  result_t               result_next;

  kpd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpd_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .item                 (stage_item),
    .cfg                  (cfg),
    .press_timer          (press_timer),
    .timer_running        (timer_running),
    .previous_levels      (previous_levels),
    .press_timer_next     (press_timer_next),
    .timer_running_next   (timer_running_next),
    .previous_levels_next (previous_levels_next),
    .result               (result_next)
  );

  // Result register is free when empty or being taken
  assign advance    = !result_valid || result_ready;
  assign item_ready = !rst && (!stage_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid     <= 1'b0;
      result_valid    <= 1'b0;
      press_timer     <= '0;
      timer_running   <= 1'b0;
      previous_levels <= '0;
    end else begin
      if (item_valid && item_ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= stage_valid;
      end
      if (stage_valid && advance) begin
        press_timer     <= press_timer_next;
        timer_running   <= timer_running_next;
        previous_levels <= previous_levels_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item_data;
    end
    if (stage_valid && advance) begin
      result_data <= result_next;
    end
  end

endmodule

[rtl/kpd_checker.sv]
// Port-level checks of the key press duration classifier, bound to the top.
// Depends on kpd_pkg and key_press_duration_classifier_macros.svh.
`include "key_press_duration_classifier_macros.svh"

module kpd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input kpd_pkg::result_t                result_data
);
  import kpd_pkg::*;

  `KPD_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !result_valid, "result valid after reset")

  `KPD_ASSERT(a_result_holds, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result_data), "stalled result changed")

  `KPD_ASSERT(a_empty_takes_request, clk, rst, !result_valid |-> item_ready, "request refused with empty output")

  `KPD_ASSERT(a_tick_result_clean, clk, rst, result_valid && result_data.led_color != LED_NO_CHANGE |-> result_data.key_event == EVENT_NONE && !result_data.mute_request && !result_data.restore_request, "LED hint mixed with key result")

  `KPD_ASSERT(a_event_range, clk, rst, result_valid |-> result_data.key_event <= EVENT_LAST, "key event code out of range")

endmodule

bind key_press_duration_classifier kpd_checker u_kpd_checker (.*);
